[rtl/core/rkp_pkg.sv]
package rkp_pkg;

	// field widths
	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 32;
	localparam int COEF_W    = 48;
	localparam int P_W       = 48;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 2;

	// square root of t * 2^FRAC_BITS, one result bit per stage
	localparam int SQX_W = VAL_W + FRAC_BITS;
	localparam int SQ_W  = (SQX_W + 1) / 2;
	localparam int SQP_W = 2 * SQ_W;
	localparam int SQR_W = SQ_W + 2;

	// denominator of the attraction term: sqrt(t) * v * (v + b)
	localparam int SV_W  = SQ_W + VAL_W;
	localparam int VPB_W = VAL_W + 1;
	localparam int DEN_W = SV_W + VPB_W;

	// numerators: a * 2^(3F) and R * t
	localparam int NUM_W = COEF_W + 3 * FRAC_BITS;
	localparam int RT_W  = 2 * VAL_W;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADIN    = 2'd1,
		ST_SINGULAR = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAS   = 2'd0,
		CFG_ATTR  = 2'd1,
		CFG_COVOL = 2'd2,
		CFG_NONE  = 2'd3
	} cfg_idx_t;

	// operands that travel beside the square root
	typedef struct packed {
		logic [VAL_W-1:0] vol;
		logic [VPB_W-1:0] vpb;
		logic [VAL_W-1:0] vmb;
		logic [RT_W-1:0]  rt;
		status_t          status;
	} side_t;

	localparam logic [P_W-1:0] P_MAX = {1'b0, {(P_W-1){1'b1}}};
	localparam logic [P_W-1:0] P_MIN = {1'b1, {(P_W-1){1'b0}}};

endpackage

[rtl/core/rkp_if.sv]
interface rkp_item_if import rkp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] volume;
	logic [VAL_W-1:0] temperature;
	modport source (output valid, volume, temperature, input ready);
	modport sink (input valid, volume, temperature, output ready);
endinterface

interface rkp_result_if import rkp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [P_W-1:0] pressure;
	logic [ST_W-1:0]       status;
	modport source (output valid, pressure, status, input ready);
	modport sink (input valid, pressure, status, output ready);
endinterface

interface rkp_cfg_if import rkp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rkp_sqrt.sv]
module rkp_sqrt import rkp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [VAL_W-1:0] temp_in,
	input  side_t            side_in,
	output logic             vld_out,
	output logic [SQ_W-1:0]  root_out,
	output side_t            side_out
);

	logic [SQR_W-1:0] rem_s  [0:SQ_W];
	logic [SQ_W-1:0]  root_s [0:SQ_W];
	logic [SQP_W-1:0] x_s    [0:SQ_W];
	side_t            side_s [0:SQ_W];
	logic             vld_s  [0:SQ_W];

	// stage zero is the incoming word
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = SQP_W'({temp_in, {FRAC_BITS{1'b0}}});
	assign side_s[0] = side_in;
	assign vld_s[0]  = vld_in;

	for (genvar k = 0; k < SQ_W; k++) begin : g_stage
		logic [SQR_W-1:0] rsh;
		logic [SQR_W-1:0] trial;

		// bring down two radicand bits, try the next root bit
		always_comb begin
			rsh   = {rem_s[k][SQR_W-3:0], x_s[k][SQP_W-1 -: 2]};
			trial = {root_s[k], 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rsh >= trial) begin
					rem_s[k+1]  <= rsh - trial;
					root_s[k+1] <= {root_s[k][SQ_W-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= rsh;
					root_s[k+1] <= {root_s[k][SQ_W-2:0], 1'b0};
				end
				x_s[k+1]    <= {x_s[k][SQP_W-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_out  = vld_s[SQ_W];
	assign root_out = root_s[SQ_W];
	assign side_out = side_s[SQ_W];

endmodule

[rtl/core/rkp_den.sv]
module rkp_den import rkp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [SQ_W-1:0]  root_in,
	input  side_t            side_in,
	output logic             vld_out,
	output logic [DEN_W-1:0] den_out,
	output logic [RT_W-1:0]  rt_out,
	output logic [VAL_W-1:0] vmb_out,
	output status_t          status_out
);

	logic [SV_W-1:0]        sv_s1;
	logic [VAL_W+VPB_W-1:0] plo_s2;
	logic [SQ_W+VPB_W-1:0]  phi_s2;
	logic [DEN_W-1:0]       den_s3;
	side_t                  side_s1, side_s2, side_s3;
	logic                   vld_s1, vld_s2, vld_s3;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// sqrt(t) * v, then two partial products by v + b, then sum them
	always_ff @(posedge clk) begin
		if (en) begin
			sv_s1   <= SV_W'(root_in) * SV_W'(side_in.vol);
			side_s1 <= side_in;
			plo_s2  <= (VAL_W+VPB_W)'(sv_s1[VAL_W-1:0]) * (VAL_W+VPB_W)'(side_s1.vpb);
			phi_s2  <= (SQ_W+VPB_W)'(sv_s1[SV_W-1:VAL_W]) * (SQ_W+VPB_W)'(side_s1.vpb);
			side_s2 <= side_s1;
			den_s3  <= DEN_W'(plo_s2) + {phi_s2, {VAL_W{1'b0}}};
			side_s3 <= side_s2;
		end
	end

	assign vld_out    = vld_s3;
	assign den_out    = den_s3;
	assign rt_out     = side_s3.rt;
	assign vmb_out    = side_s3.vmb;
	assign status_out = side_s3.status;

endmodule

[rtl/core/rkp_div.sv]
module rkp_div import rkp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [RT_W-1:0]  num1_in,
	input  logic [NUM_W-1:0] num2_in,
	input  logic [VAL_W-1:0] den1_in,
	input  logic [DEN_W-1:0] den2_in,
	input  status_t          status_in,
	output logic             vld_out,
	output logic [NUM_W-1:0] quo1_out,
	output logic [NUM_W-1:0] quo2_out,
	output status_t          status_out
);

	// lane 1: R*t / (v-b); lane 2: a*2^(3F) / den
	// q holds the numerator bits still to use, low end fills with quotient bits
	logic [VAL_W-1:0] rem1_s [0:NUM_W];
	logic [NUM_W-1:0] q1_s   [0:NUM_W];
	logic [VAL_W-1:0] d1_s   [0:NUM_W];
	logic [DEN_W-1:0] rem2_s [0:NUM_W];
	logic [NUM_W-1:0] q2_s   [0:NUM_W];
	logic [DEN_W-1:0] d2_s   [0:NUM_W];
	status_t          st_s   [0:NUM_W];
	logic             vld_s  [0:NUM_W];

	assign rem1_s[0] = '0;
	assign q1_s[0]   = NUM_W'(num1_in);
	assign d1_s[0]   = den1_in;
	assign rem2_s[0] = '0;
	assign q2_s[0]   = num2_in;
	assign d2_s[0]   = den2_in;
	assign st_s[0]   = status_in;
	assign vld_s[0]  = vld_in;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [VAL_W:0] rs1;
		logic [DEN_W:0] rs2;
		logic           ge1, ge2;

		// shift in the next numerator bit, compare with the divisor
		always_comb begin
			rs1 = {rem1_s[k], q1_s[k][NUM_W-1]};
			rs2 = {rem2_s[k], q2_s[k][NUM_W-1]};
			ge1 = rs1 >= {1'b0, d1_s[k]};
			ge2 = rs2 >= {1'b0, d2_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem1_s[k+1] <= ge1 ? VAL_W'(rs1 - {1'b0, d1_s[k]}) : rs1[VAL_W-1:0];
				q1_s[k+1]   <= {q1_s[k][NUM_W-2:0], ge1};
				rem2_s[k+1] <= ge2 ? DEN_W'(rs2 - {1'b0, d2_s[k]}) : rs2[DEN_W-1:0];
				q2_s[k+1]   <= {q2_s[k][NUM_W-2:0], ge2};
				d1_s[k+1]   <= d1_s[k];
				d2_s[k+1]   <= d2_s[k];
				st_s[k+1]   <= st_s[k];
			end
		end
	end

	assign vld_out    = vld_s[NUM_W];
	assign quo1_out   = q1_s[NUM_W];
	assign quo2_out   = q2_s[NUM_W];
	assign status_out = st_s[NUM_W];

endmodule

[rtl/core/redlich_kwong_pressure_top.sv]
// Redlich-Kwong pressure p = R*t/(v-b) - a/(sqrt(t)*v*(v+b)) for a stream of
// (volume, temperature) words, one result word per input word, in order.
// A new word is taken every clock cycle while the output is not held; the
// pipeline runs an input register stage, the bit-per-stage square root
// (SQ_W = 24 stages), the denominator products and the bit-per-stage divider
// (NUM_W = 96 stages). The whole pipeline holds while a finished result is
// not taken. Zero volume or temperature reports status 1, v <= b status 2,
// both with zero pressure; an out-of-range pressure clamps and reports
// status 3. Write R, a and b only while no word is in flight.
module redlich_kwong_pressure_top import rkp_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	rkp_cfg_if.sink      cfg,
	rkp_item_if.sink     item,
	rkp_result_if.source result
);

	logic [VAL_W-1:0]  gas_q;
	logic [COEF_W-1:0] attr_q;
	logic [VAL_W-1:0]  covol_q;
	logic              en;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_q   <= '0;
			attr_q  <= '0;
			covol_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_GAS:   gas_q   <= cfg.data[VAL_W-1:0];
				CFG_ATTR:  attr_q  <= cfg.data;
				CFG_COVOL: covol_q <= cfg.data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// hold the whole pipeline while the output word waits
	logic out_vld_q;
	assign en         = !out_vld_q || result.ready;
	assign item.ready = en;

	// stage 1: R*t, v-b, v+b and the input checks
	logic             vld_s1;
	logic [VAL_W-1:0] temp_s1;
	side_t            side_s1;
	status_t          st_in;

	always_comb begin
		if (item.volume == '0 || item.temperature == '0) begin
			st_in = ST_BADIN;
		end else if (item.volume <= covol_q) begin
			st_in = ST_SINGULAR;
		end else begin
			st_in = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s1        <= item.temperature;
			side_s1.vol    <= item.volume;
			side_s1.vpb    <= VPB_W'(item.volume) + VPB_W'(covol_q);
			side_s1.vmb    <= item.volume - covol_q;
			side_s1.rt     <= RT_W'(gas_q) * RT_W'(item.temperature);
			side_s1.status <= st_in;
		end
	end

	// square root of the temperature
	logic            sq_vld;
	logic [SQ_W-1:0] sq_root;
	side_t           sq_side;

	rkp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s1),
		.temp_in  (temp_s1),
		.side_in  (side_s1),
		.vld_out  (sq_vld),
		.root_out (sq_root),
		.side_out (sq_side)
	);

	// denominator of the attraction term
	logic             dn_vld;
	logic [DEN_W-1:0] dn_den;
	logic [RT_W-1:0]  dn_rt;
	logic [VAL_W-1:0] dn_vmb;
	status_t          dn_status;

	rkp_den u_den (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (sq_vld),
		.root_in    (sq_root),
		.side_in    (sq_side),
		.vld_out    (dn_vld),
		.den_out    (dn_den),
		.rt_out     (dn_rt),
		.vmb_out    (dn_vmb),
		.status_out (dn_status)
	);

	// both divisions in lockstep
	logic             dv_vld;
	logic [NUM_W-1:0] dv_q1;
	logic [NUM_W-1:0] dv_q2;
	status_t          dv_status;
	logic [NUM_W-1:0] num2;

	assign num2 = {attr_q, {(3*FRAC_BITS){1'b0}}};

	rkp_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (dn_vld),
		.num1_in    (dn_rt),
		.den1_in    (dn_vmb),
		.num2_in    (num2),
		.den2_in    (dn_den),
		.status_in  (dn_status),
		.vld_out    (dv_vld),
		.quo1_out   (dv_q1),
		.quo2_out   (dv_q2),
		.status_out (dv_status)
	);

	// subtract the terms, clamp to the pressure range
	logic signed [RT_W:0] diff;
	logic                 big2, in_range;
	logic [P_W-1:0]       p_nx;
	status_t              st_nx;

	always_comb begin
		big2     = |dv_q2[NUM_W-1:RT_W];
		diff     = $signed({1'b0, dv_q1[RT_W-1:0]}) - $signed({1'b0, dv_q2[RT_W-1:0]});
		in_range = (diff[RT_W:P_W-1] == '0) || (diff[RT_W:P_W-1] == '1);
		if (dv_status != ST_OK) begin
			p_nx  = '0;
			st_nx = dv_status;
		end else if (big2 || (diff[RT_W] && !in_range)) begin
			p_nx  = P_MIN;
			st_nx = ST_SAT;
		end else if (!in_range) begin
			p_nx  = P_MAX;
			st_nx = ST_SAT;
		end else begin
			p_nx  = diff[P_W-1:0];
			st_nx = ST_OK;
		end
	end

	logic [P_W-1:0] p_q;
	status_t        st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q  <= p_nx;
			st_q <= st_nx;
		end
	end

	assign result.valid    = out_vld_q;
	assign result.pressure = $signed(p_q);
	assign result.status   = st_q;

	// error words carry zero pressure
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (st_q == ST_BADIN || st_q == ST_SINGULAR) |-> p_q == '0)
		else $error("error word with nonzero pressure");

	// a saturated word sits on a range bound
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && st_q == ST_SAT |-> (p_q == P_MAX || p_q == P_MIN))
		else $error("saturated word off the bound");

	// input is taken exactly when the output side can move
	assert property (@(posedge clk) disable iff (!arst_n)
		item.ready == (!out_vld_q || result.ready))
		else $error("input ready out of step with output");

	// a held output word does not change
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !result.ready |=> $stable(p_q) && $stable(st_q))
		else $error("stalled word changed");

endmodule

[tb/redlich_kwong_pressure_top_tb.sv]
`timescale 1ns / 100ps

module redlich_kwong_pressure_top_tb;
	import rkp_pkg::*;

	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  DRAIN_WAIT  = 140;
	localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;

	typedef struct packed {
		logic signed [P_W-1:0] pressure;
		status_t               status;
	} point_result_t;

	logic clk;
	logic arst_n;

	rkp_cfg_if    cfg_bus ();
	rkp_item_if   item_bus ();
	rkp_result_if result_bus ();

	redlich_kwong_pressure_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus.sink),
		.item   (item_bus.sink),
		.result (result_bus.source)
	);

	// local copy of the coefficient registers
	logic [VAL_W-1:0]  r_gas;
	logic [COEF_W-1:0] r_attr;
	logic [VAL_W-1:0]  r_covol;

	point_result_t pressure_q[$];
	int            mismatches;
	int            cycles;
	int            hold_req;
	bit            rx_no_idle;
	bit            tx_no_idle;

	// integer square root, one result bit per step
	function automatic logic [63:0] isqrt64(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// pressure of one state point under the current coefficients
	function automatic point_result_t calc_pressure(logic [VAL_W-1:0] v, logic [VAL_W-1:0] t);
		point_result_t r;
		logic [127:0]  term1;
		logic [127:0]  term2;
		logic [127:0]  den;
		logic [127:0]  num;
		logic [127:0]  mag;
		logic [63:0]   s;
		r.pressure = '0;
		r.status   = ST_OK;
		if (v == 0 || t == 0) begin
			r.status = ST_BADIN;
			return r;
		end
		if (v <= r_covol) begin
			r.status = ST_SINGULAR;
			return r;
		end
		term1 = 128'((64'(r_gas) * 64'(t)) / 64'(v - r_covol));
		s     = isqrt64(64'(t) << FRAC_BITS);
		den   = 128'(s) * 128'(v) * (128'(v) + 128'(r_covol));
		num   = 128'(r_attr) << (3 * FRAC_BITS);
		term2 = num / den;
		if (term1 >= term2) begin
			mag = term1 - term2;
			if (mag > 128'(P_MAX)) begin
				r.pressure = P_MAX;
				r.status   = ST_SAT;
			end else begin
				r.pressure = mag[P_W-1:0];
			end
		end else begin
			mag = term2 - term1;
			if (mag > 128'(P_MAX) + 1) begin
				r.pressure = P_MIN;
				r.status   = ST_SAT;
			end else begin
				r.pressure = -$signed(mag[P_W-1:0]);
			end
		end
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// receiver: random stalls, occasional long hold-offs, a long hold-off on request, no stalls in no-idle mode
	initial begin
		int hold_cnt;
		hold_cnt         = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				result_bus.ready = 1'b0;
			end else if (rx_no_idle) begin
				result_bus.ready = 1'b1;
			end else if ($urandom_range(0, 199) == 0) begin
				hold_cnt         = $urandom_range(20, 80);
				result_bus.ready = 1'b0;
			end else begin
				result_bus.ready = ($urandom_range(0, 9) < 7);
			end
		end
	end

	// compare each result word with the oldest expected pressure
	initial begin
		point_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (pressure_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: pressure %0d status %0d",
							result_bus.pressure, result_bus.status);
				end else begin
					want = pressure_q.pop_front();
					if (result_bus.pressure !== want.pressure ||
					    result_bus.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: pressure exp %0d got %0d, status exp %0d got %0d",
								want.pressure, result_bus.pressure, want.status,
								result_bus.status);
					end
				end
			end
		end
	end

	// send one coefficient word and mirror it
	task automatic write_coef(cfg_idx_t idx, logic [COEF_W-1:0] data);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data  = data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			CFG_GAS:   r_gas   = data[VAL_W-1:0];
			CFG_ATTR:  r_attr  = data;
			CFG_COVOL: r_covol = data[VAL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic set_coefs(logic [VAL_W-1:0] g, logic [COEF_W-1:0] a, logic [VAL_W-1:0] b);
		write_coef(CFG_GAS, COEF_W'(g));
		write_coef(CFG_ATTR, a);
		write_coef(CFG_COVOL, COEF_W'(b));
	endtask

	// send one state point; valid stays high into the next word unless a random gap is drawn (never in no-idle mode)
	task automatic send_point(logic [VAL_W-1:0] v, logic [VAL_W-1:0] t);
		int gap;
		gap = 0;
		if (!tx_no_idle) begin
			if ($urandom_range(0, 19) == 0)
				gap = $urandom_range(10, 40);
			else if ($urandom_range(0, 2) == 0)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			item_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid       = 1'b1;
		item_bus.volume      = v;
		item_bus.temperature = t;
		do @(posedge clk); while (!item_bus.ready);
		pressure_q.push_back(calc_pressure(v, t));
		@(negedge clk);
	endtask

	// drop valid and wait out every expected word plus the pipeline depth
	task automatic wait_drained();
		item_bus.valid = 1'b0;
		while (pressure_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// random point, mostly well formed with v above b
	task automatic send_random_point();
		logic [63:0] span;
		logic [63:0] v;
		logic [63:0] t;
		int          kind;
		kind = $urandom_range(0, 9);
		t    = 64'($urandom_range(1, 32'hFFFF_FFFF));
		v    = 64'($urandom);
		span = MAX32 - 64'(r_covol);
		if (kind == 0) begin
			v = 64'($urandom);
			t = 64'($urandom);
		end else if (kind == 1) begin
			v = 64'(r_covol) - 64'($urandom_range(0, 3));
			v = (v > MAX32) ? 0 : v;
		end else if (kind == 2) begin
			if ($urandom_range(0, 1)) v = 0; else t = 0;
			if (v != 0 || t != 0) v = (v == 0) ? 0 : 64'($urandom);
		end else if (span == 0) begin
			v = 64'($urandom);
		end else if (kind < 6) begin
			v = 64'(r_covol) + 1 + ({$urandom, $urandom} % (span > 4096 ? 4096 : span));
		end else begin
			v = 64'(r_covol) + 1 + ({$urandom, $urandom} % span);
		end
		send_point(v[VAL_W-1:0], t[VAL_W-1:0]);
	endtask

	task automatic test_reset_values();
		send_point(32'd1, 32'd1);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h0001_0000, 32'h0001_0000);
		wait_drained();
	endtask

	task automatic test_special_points();
		set_coefs(32'h0000_8000, 48'h0000_1234_5678, 32'h0000_1000);
		send_point(32'd0, 32'h0001_0000);
		send_point(32'h0002_0000, 32'd0);
		send_point(32'd0, 32'd0);
		send_point(32'h0000_1000, 32'h0001_0000);
		send_point(32'h0000_0FFF, 32'h0001_0000);
		send_point(32'h0000_1001, 32'h0001_0000);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'd1);
		send_point(32'h0000_1001, 32'hFFFF_FFFF);
		send_point(32'h0010_0000, 32'h0123_4567);
		wait_drained();
	endtask

	task automatic test_saturation();
		// huge positive term: R and t at full scale, tiny v - b
		set_coefs(32'hFFFF_FFFF, 48'd0, 32'd0);
		send_point(32'd1, 32'hFFFF_FFFF);
		send_point(32'd2, 32'h8000_0000);
		wait_drained();
		// huge attraction term against a small repulsion
		set_coefs(32'd1, 48'hFFFF_FFFF_FFFF, 32'd0);
		send_point(32'd1, 32'd1);
		send_point(32'h0000_0100, 32'h0000_0100);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
		// b at full scale: every point is singular
		set_coefs(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'd5);
		wait_drained();
	endtask

	task automatic test_unused_index();
		set_coefs(32'h0002_0000, 48'h0000_0040_0000, 32'h0000_0800);
		write_coef(CFG_NONE, 48'hFFFF_FFFF_FFFF);
		send_point(32'h0001_0000, 32'h0004_0000);
		send_point(32'h0000_0801, 32'h0000_0001);
		wait_drained();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_coefs(32'h0000_8500, 48'h0000_0A00_0000, 32'h0000_0200);
				1: set_coefs($urandom, COEF_W'({$urandom, $urandom}),
					$urandom_range(0, 32'h00FF_FFFF));
				2: set_coefs(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd0);
				3: set_coefs(32'd0, 48'd0, $urandom);
				default: set_coefs($urandom, COEF_W'({$urandom, $urandom}),
					$urandom);
			endcase
			tx_no_idle = (ph == 1);
			rx_no_idle = (ph == 3);
			for (int n = 0; n < 120; n++)
				send_random_point();
			tx_no_idle = 1'b0;
			rx_no_idle = 1'b0;
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		set_coefs(32'h0001_2000, 48'h0000_3000_0000, 32'h0000_0400);
		tx_no_idle = 1'b1;
		hold_req   = 500;
		for (int n = 0; n < 200; n++)
			send_random_point();
		tx_no_idle = 1'b0;
		wait_drained();
	endtask

	initial begin
		mismatches           = 0;
		hold_req             = 0;
		rx_no_idle           = 1'b0;
		tx_no_idle           = 1'b0;
		r_gas                = '0;
		r_attr               = '0;
		r_covol              = '0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.index        = CFG_GAS;
		cfg_bus.data         = '0;
		item_bus.valid       = 1'b0;
		item_bus.volume      = '0;
		item_bus.temperature = '0;
		arst_n               = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_special_points();
		test_saturation();
		test_unused_index();
		test_random_phases();
		test_backpressure();

		if (mismatches == 0 && pressure_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
